FILE: hw/rtl/gbc_pkg.sv
// ----------------------------------------------------------------------------
// gbc_pkg
// Shared types and codes of the two-button gesture classifier.
// ----------------------------------------------------------------------------
package gbc_pkg;

  // Item kinds on the input channel.
  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_EDGE = 1'b1
  } cmd_t;

  // Gesture codes on the result channel.
  localparam logic [2:0] GEST_NONE        = 3'd0;
  localparam logic [2:0] GEST_START_SHORT = 3'd1;
  localparam logic [2:0] GEST_SETUP_SHORT = 3'd2;
  localparam logic [2:0] GEST_CHORD_SHORT = 3'd3;
  localparam logic [2:0] GEST_START_LONG  = 3'd4;
  localparam logic [2:0] GEST_SETUP_LONG  = 3'd5;
  localparam logic [2:0] GEST_CHORD_LONG  = 3'd6;

  // A long gesture code is the chord mask plus this offset.
  localparam logic [2:0] GEST_LONG_OFFSET = 3'd3;

  // Button masks: bit 0 start, bit 1 setup.
  localparam logic [1:0] MASK_NONE  = 2'b00;
  localparam logic [1:0] MASK_START = 2'b01;
  localparam logic [1:0] MASK_SETUP = 2'b10;
  localparam logic [1:0] MASK_BOTH  = 2'b11;

  // Beeper requests.
  localparam logic [1:0] BEEP_NONE  = 2'd0;
  localparam logic [1:0] BEEP_CLICK = 2'd1;
  localparam logic [1:0] BEEP_LONG  = 2'd2;

  localparam logic [15:0] HOLD_TICKS_RESET = 16'd2000;

  typedef struct packed {
    logic cmd;
    logic button;
    logic pressed;
  } in_item_t;

  typedef struct packed {
    logic [2:0] gesture;
    logic [2:0] mode_index;
    logic       lock_on;
    logic [1:0] beep;
  } out_item_t;

endpackage

FILE: hw/rtl/gbc_if.sv
// ----------------------------------------------------------------------------
// gbc_if
// Valid/ready channels of the two-button gesture classifier.
// ----------------------------------------------------------------------------
interface gbc_in_if;
  logic             valid;
  logic             ready;
  gbc_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gbc_out_if;
  logic               valid;
  logic               ready;
  gbc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gbc_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/two_button_gesture_classifier_top.sv
// ----------------------------------------------------------------------------
// two_button_gesture_classifier_top
// Classifies start/setup button activity into short, long and chord gestures.
//
//   channel   dir  payload                              handshake
//   items     in   cmd, button, pressed                 valid/ready
//   results   out  gesture, mode_index, lock_on, beep   valid/ready
//   cfg       in   hold_ticks (16 bit)                  valid/ready
//
// Every item gives one result: it is taken into the input register, then the
// state update writes the result register. One item per cycle is sustained
// while results is ready; the single state update sets that figure.
// Reset (synchronous, active high) clears all state and sets hold_ticks to
// 2000. A stalled result holds the result register; the input register still
// takes one more item, and items stops only when both are full.
// ----------------------------------------------------------------------------
module two_button_gesture_classifier_top #(
  parameter int MODE_COUNT = 6
) (
  input  logic clk,
  input  logic rst,
  gbc_in_if.sink    items,
  gbc_out_if.source results,
  gbc_cfg_if.sink   cfg
);
  import gbc_pkg::*;

  localparam logic [3:0] MODE_LIMIT = 4'(MODE_COUNT);

  logic [15:0] hold_ticks;

  // Input register.
  logic     s1_valid;
  in_item_t s1_item;

  // Classifier state.
  logic [1:0]  held_mask,  held_mask_next;
  logic [1:0]  chord_mask, chord_mask_next;
  logic        lock_flag,  lock_flag_next;
  logic        long_done,  long_done_next;
  logic        hold_armed, hold_armed_next;
  logic [15:0] hold_count, hold_count_next;
  logic [2:0]  mode_sel,   mode_sel_next;

  // Result register.
  logic      res_valid;
  out_item_t res_item, res_item_next;

  logic       s1_fire;
  logic [1:0] bit_sel;
  logic       level_now;
  logic [2:0] mode_inc;

  assign s1_fire     = s1_valid && (!res_valid || results.ready);
  assign items.ready = !s1_valid || s1_fire;
  assign cfg.ready   = 1'b1;

  assign results.valid = res_valid;
  assign results.data  = res_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_ticks <= HOLD_TICKS_RESET;
    end else if (cfg.valid) begin
      hold_ticks <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (items.ready) begin
      s1_valid <= items.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (items.ready && items.valid) begin
      s1_item <= items.data;
    end
  end

  always_comb begin
    bit_sel   = s1_item.button ? MASK_SETUP : MASK_START;
    level_now = |(held_mask & bit_sel);
    mode_inc  = mode_sel + 3'd1;

    held_mask_next  = held_mask;
    chord_mask_next = chord_mask;
    lock_flag_next  = lock_flag;
    long_done_next  = long_done;
    hold_armed_next = hold_armed;
    hold_count_next = hold_count;
    mode_sel_next   = mode_sel;
    res_item_next   = '0;
    res_item_next.gesture = GEST_NONE;
    res_item_next.beep    = BEEP_NONE;

    if (s1_item.cmd == CMD_EDGE) begin
      // An edge that repeats the current level is ignored.
      if (level_now != s1_item.pressed) begin
        if (s1_item.pressed) begin
          if (!lock_flag) begin
            res_item_next.beep = BEEP_CLICK;
          end
          hold_count_next = hold_ticks;
          hold_armed_next = 1'b1;
          long_done_next  = 1'b0;
          held_mask_next  = held_mask | bit_sel;
          chord_mask_next = chord_mask | bit_sel;
        end else begin
          hold_armed_next = 1'b0;
          held_mask_next  = held_mask & ~bit_sel;
          if (held_mask_next == MASK_NONE) begin
            if (!lock_flag && !long_done) begin
              res_item_next.gesture = {1'b0, chord_mask};
              if (chord_mask == MASK_SETUP) begin
                mode_sel_next = ({1'b0, mode_inc} >= MODE_LIMIT) ? 3'd0 : mode_inc;
              end
            end
            chord_mask_next = MASK_NONE;
          end
        end
      end
    end else if (hold_armed) begin
      // A count loaded as zero expires on the next tick, like a count of one.
      if (hold_count > 16'd1) begin
        hold_count_next = hold_count - 16'd1;
      end else begin
        hold_count_next = 16'd0;
        if (chord_mask != MASK_NONE) begin
          res_item_next.gesture = {1'b0, chord_mask} + GEST_LONG_OFFSET;
          res_item_next.beep    = BEEP_LONG;
          if (chord_mask == MASK_BOTH) begin
            lock_flag_next = !lock_flag;
          end
        end
        long_done_next  = 1'b1;
        hold_armed_next = 1'b0;
      end
    end

    res_item_next.mode_index = mode_sel_next;
    res_item_next.lock_on    = lock_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_mask  <= MASK_NONE;
      chord_mask <= MASK_NONE;
      lock_flag  <= 1'b0;
      long_done  <= 1'b0;
      hold_armed <= 1'b0;
      hold_count <= 16'd0;
      mode_sel   <= 3'd0;
    end else if (s1_fire) begin
      held_mask  <= held_mask_next;
      chord_mask <= chord_mask_next;
      lock_flag  <= lock_flag_next;
      long_done  <= long_done_next;
      hold_armed <= hold_armed_next;
      hold_count <= hold_count_next;
      mode_sel   <= mode_sel_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || results.ready) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_item <= res_item_next;
    end
  end

  // A running countdown always belongs to a button that is still down.
  a_armed_needs_held: assert property (@(posedge clk) disable iff (rst)
    hold_armed |-> (held_mask != MASK_NONE))
    else $error("hold countdown armed with no button held");

  // Every held button is part of the current chord.
  a_held_in_chord: assert property (@(posedge clk) disable iff (rst)
    (held_mask & ~chord_mask) == MASK_NONE)
    else $error("held button missing from chord mask");

  a_mode_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, mode_sel} < MODE_LIMIT)
    else $error("mode index out of range");

  // The long beep only comes with a long gesture.
  a_long_beep: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_item.beep == BEEP_LONG) |->
      (res_item.gesture == GEST_START_LONG || res_item.gesture == GEST_SETUP_LONG ||
       res_item.gesture == GEST_CHORD_LONG))
    else $error("long beep without long gesture");

endmodule
